[sv/tdbl_pkg.sv]
`timescale 1ns / 1ps

package tdbl_pkg;

   // Fixed field widths
   localparam int NODE_W = 10;
   localparam int OP_W   = 2;
   localparam int DIST_W = 11;

   // Distance saturates here on inconsistent tables
   localparam logic [DIST_W-1:0] DIST_MAX = 11'h7FF;

   // Item operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_NODE,
      ST_B_HOP,
      ST_B_WR,
      ST_Q_DB,
      ST_Q_SWAP,
      ST_Q_LIFT,
      ST_Q_LIFT_WAIT,
      ST_Q_CMP,
      ST_Q_UA,
      ST_Q_UB,
      ST_Q_UC,
      ST_Q_DONE
   } state_type;

endpackage

[sv/tdbl_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module tdbl_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tree_distance_binary_lifting.sv]
`timescale 1ns / 1ps

// Tree distance engine (binary lifting). Software loads each node's parent and
// depth with a load item (no result), issues a build item to fill the
// ancestor jump table, then sends query items that each return the edge count
// between two nodes. Node 0 is the sentinel and reads as depth 0 with every
// ancestor 0; node numbers not below MAX_NODES act the same way. Tables hold
// garbage after reset until loaded. One item is worked on at a time and the
// single read port of the jump-table RAM sets the pace: a build reads, hops and
// writes each node at each of levels 1..LEVELS-1; a query does the depth
// lookups, lifts the deeper node one level per step (waiting for the read when
// a jump is taken), compares and, if the nodes still differ, lifts both through
// each level (read a's ancestor, read b's ancestor, compare and move), then
// posts the result. A finished result waits in an output register, so the next
// item is taken while it is still pending. Operation code 3 is dropped.
module tree_distance_binary_lifting #(
   parameter int MAX_NODES = 1024,
   parameter int LEVELS    = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tdbl_pkg::OP_W-1:0]   req_operation,
   input  logic [tdbl_pkg::NODE_W-1:0] req_node_a,
   input  logic [tdbl_pkg::NODE_W-1:0] req_node_b,
   input  logic [tdbl_pkg::NODE_W-1:0] req_parent_node,
   input  logic [tdbl_pkg::NODE_W-1:0] req_node_depth,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tdbl_pkg::DIST_W-1:0] rsp_distance,
   // node count register
   input  logic                        csr_write_enable,
   input  logic [tdbl_pkg::NODE_W-1:0] csr_write_data
);

   localparam int NW     = tdbl_pkg::NODE_W;
   localparam int AW     = $clog2(MAX_NODES);
   localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JAW    = AW + LW;
   localparam int JDEPTH = MAX_NODES * (2 ** LW);
   localparam int NCW    = NW + 1;
   localparam int ACC_W  = ((LEVELS > NW) ? LEVELS : NW) + 2;

   localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

   // Real node: not the sentinel and inside the table
   function automatic logic is_real(input logic [NW-1:0] n);
      return (n != '0) && (32'(n) < MAX_NODES);
   endfunction

   // Jump-table address of (node, level)
   function automatic logic [JAW-1:0] jaddr(input logic [NW-1:0] n, input logic [LW-1:0] l);
      return {AW'(n), l};
   endfunction

   // Registers
   tdbl_pkg::state_type state_ff, state_in;
   logic [LW-1:0]    lvl_ff, lvl_in;
   logic [NCW-1:0]   node_ff, node_in;
   logic [NW-1:0]    a_ff, a_in;
   logic [NW-1:0]    b_ff, b_in;
   logic [NW-1:0]    da_ff, da_in;
   logic [NW-1:0]    ra_ff, ra_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             rd_zero_ff, rd_zero_in;
   logic [NW-1:0]    node_count_ff, node_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [tdbl_pkg::DIST_W-1:0] rsp_distance_ff, rsp_distance_in;

   // Memory ports
   logic            jw_en;
   logic [JAW-1:0]  jw_addr;
   logic [NW-1:0]   jw_data;
   logic [JAW-1:0]  jr_addr;
   logic [NW-1:0]   jr_data;
   logic            dw_en;
   logic [AW-1:0]   dr_addr;
   logic [NW-1:0]   dr_data;

   // Sentinel reads come back as zero
   logic [NW-1:0]    j_val;
   logic [NW-1:0]    d_val;
   logic             req_accept;
   logic             slot_free;
   logic [ACC_W-1:0] acc_shift;
   logic [ACC_W-1:0] acc_step;
   tdbl_pkg::op_type req_op;

   assign j_val      = rd_zero_ff ? '0 : jr_data;
   assign d_val      = rd_zero_ff ? '0 : dr_data;
   assign req_stall  = (state_ff != tdbl_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_op     = tdbl_pkg::op_type'(req_operation);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign acc_shift  = acc_ff >> lvl_ff;
   assign acc_step   = ACC_W'(2) << lvl_ff;

   tdbl_ram #(.WIDTH(NW), .DEPTH(JDEPTH)) u_jump_ram (
      .clock   (clock),
      .wr_en   (jw_en),
      .wr_addr (jw_addr),
      .wr_data (jw_data),
      .rd_addr (jr_addr),
      .rd_data (jr_data)
   );

   tdbl_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_depth_ram (
      .clock   (clock),
      .wr_en   (dw_en),
      .wr_addr (AW'(req_node_a)),
      .wr_data (req_node_depth),
      .rd_addr (dr_addr),
      .rd_data (dr_data)
   );

   // Sequencer: next state, datapath and memory ports
   always_comb begin
      state_in        = state_ff;
      lvl_in          = lvl_ff;
      node_in         = node_ff;
      a_in            = a_ff;
      b_in            = b_ff;
      da_in           = da_ff;
      ra_in           = ra_ff;
      acc_in          = acc_ff;
      rd_zero_in      = 1'b0;
      node_count_in   = csr_write_enable ? csr_write_data : node_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_distance_in = rsp_distance_ff;
      jw_en           = 1'b0;
      jw_addr         = jaddr(req_node_a, '0);
      jw_data         = req_parent_node;
      jr_addr         = jaddr(b_ff, lvl_ff);
      dw_en           = 1'b0;
      dr_addr         = AW'(req_node_a);

      unique case (state_ff)
         tdbl_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_op)
                  tdbl_pkg::OP_LOAD: begin
                     jw_en = is_real(req_node_a);
                     dw_en = is_real(req_node_a);
                  end
                  tdbl_pkg::OP_BUILD: begin
                     lvl_in  = LW'(1);
                     node_in = NCW'(1);
                     if (LEVELS > 1) begin
                        state_in = tdbl_pkg::ST_B_NODE;
                     end
                  end
                  tdbl_pkg::OP_QUERY: begin
                     a_in       = req_node_a;
                     b_in       = req_node_b;
                     rd_zero_in = !is_real(req_node_a);
                     state_in   = tdbl_pkg::ST_Q_DB;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Build: walk nodes 1..node_count at each level
         tdbl_pkg::ST_B_NODE: begin
            jr_addr = jaddr(node_ff[NW-1:0], lvl_ff - LW'(1));
            if ((node_ff <= {1'b0, node_count_ff}) && (32'(node_ff) < MAX_NODES)) begin
               state_in = tdbl_pkg::ST_B_HOP;
            end else if (lvl_ff == LVL_TOP) begin
               state_in = tdbl_pkg::ST_IDLE;
            end else begin
               lvl_in  = lvl_ff + LW'(1);
               node_in = NCW'(1);
            end
         end

         tdbl_pkg::ST_B_HOP: begin
            jr_addr    = jaddr(jr_data, lvl_ff - LW'(1));
            rd_zero_in = !is_real(jr_data);
            state_in   = tdbl_pkg::ST_B_WR;
         end

         tdbl_pkg::ST_B_WR: begin
            jw_en    = 1'b1;
            jw_addr  = jaddr(node_ff[NW-1:0], lvl_ff);
            jw_data  = j_val;
            node_in  = node_ff + NCW'(1);
            state_in = tdbl_pkg::ST_B_NODE;
         end

         // Query: fetch both depths
         tdbl_pkg::ST_Q_DB: begin
            da_in      = d_val;
            dr_addr    = AW'(b_ff);
            rd_zero_in = !is_real(b_ff);
            state_in   = tdbl_pkg::ST_Q_SWAP;
         end

         // Keep the deeper node in b
         tdbl_pkg::ST_Q_SWAP: begin
            if (da_ff > d_val) begin
               a_in   = b_ff;
               b_in   = a_ff;
               acc_in = ACC_W'(da_ff - d_val);
            end else begin
               acc_in = ACC_W'(d_val - da_ff);
            end
            lvl_in   = LVL_TOP;
            state_in = tdbl_pkg::ST_Q_LIFT;
         end

         // Lift b by the depth difference, one level per step
         tdbl_pkg::ST_Q_LIFT: begin
            jr_addr = jaddr(b_ff, lvl_ff);
            if (acc_shift[0] && is_real(b_ff)) begin
               state_in = tdbl_pkg::ST_Q_LIFT_WAIT;
            end else begin
               if (acc_shift[0]) begin
                  b_in = '0;
               end
               if (lvl_ff == '0) begin
                  state_in = tdbl_pkg::ST_Q_CMP;
               end else begin
                  lvl_in = lvl_ff - LW'(1);
               end
            end
         end

         tdbl_pkg::ST_Q_LIFT_WAIT: begin
            b_in = j_val;
            if (lvl_ff == '0) begin
               state_in = tdbl_pkg::ST_Q_CMP;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = tdbl_pkg::ST_Q_LIFT;
            end
         end

         tdbl_pkg::ST_Q_CMP: begin
            lvl_in = LVL_TOP;
            if (a_ff == b_ff) begin
               state_in = tdbl_pkg::ST_Q_DONE;
            end else begin
               state_in = tdbl_pkg::ST_Q_UA;
            end
         end

         // Lift both while their ancestors differ
         tdbl_pkg::ST_Q_UA: begin
            jr_addr    = jaddr(a_ff, lvl_ff);
            rd_zero_in = !is_real(a_ff);
            state_in   = tdbl_pkg::ST_Q_UB;
         end

         tdbl_pkg::ST_Q_UB: begin
            ra_in      = j_val;
            jr_addr    = jaddr(b_ff, lvl_ff);
            rd_zero_in = !is_real(b_ff);
            state_in   = tdbl_pkg::ST_Q_UC;
         end

         tdbl_pkg::ST_Q_UC: begin
            if (ra_ff != j_val) begin
               a_in   = ra_ff;
               b_in   = j_val;
               acc_in = acc_ff + acc_step;
            end
            if (lvl_ff == '0) begin
               // final edge pair up to the common ancestor
               acc_in   = acc_in + ACC_W'(2);
               state_in = tdbl_pkg::ST_Q_DONE;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = tdbl_pkg::ST_Q_UA;
            end
         end

         // Post the result once the output register is free
         tdbl_pkg::ST_Q_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (acc_ff > ACC_W'(tdbl_pkg::DIST_MAX)) begin
                  rsp_distance_in = tdbl_pkg::DIST_MAX;
               end else begin
                  rsp_distance_in = acc_ff[tdbl_pkg::DIST_W-1:0];
               end
               state_in = tdbl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tdbl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdbl_pkg::ST_IDLE;
         node_count_ff <= NW'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      lvl_ff          <= lvl_in;
      node_ff         <= node_in;
      a_ff            <= a_in;
      b_ff            <= b_in;
      da_ff           <= da_in;
      ra_ff           <= ra_in;
      acc_ff          <= acc_in;
      rd_zero_ff      <= rd_zero_in;
      rsp_distance_ff <= rsp_distance_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

   // A query always goes on to the second depth lookup
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_op == tdbl_pkg::OP_QUERY)) |=> (state_ff == tdbl_pkg::ST_Q_DB))
      else $error("query did not start its depth lookup");

   // Depth memory is written only by a load in idle
   assert property (@(posedge clock) disable iff (reset)
      dw_en |-> ((state_ff == tdbl_pkg::ST_IDLE) && req_accept))
      else $error("depth write outside a load");

   // Build never overwrites level 0 parents
   assert property (@(posedge clock) disable iff (reset)
      (jw_en && (state_ff != tdbl_pkg::ST_IDLE)) |-> (jw_addr[LW-1:0] != '0))
      else $error("build wrote level 0");

   // A finished query posts its result when the slot is free
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == tdbl_pkg::ST_Q_DONE) && slot_free) |=> (rsp_valid_ff
         && (state_ff == tdbl_pkg::ST_IDLE)))
      else $error("query result not posted");

endmodule
